>>> rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Types, codes and helpers shared by the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  typedef enum logic [1:0] {
    REQ_PAT_CHAR  = 2'd0,
    REQ_PAT_END   = 2'd1,
    REQ_DATA_CHAR = 2'd2,
    REQ_DATA_END  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_STORE = 2'd1,
    OP_DATA  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    kind_t      kind;
    logic [7:0] chr;
    logic       fresh;
    logic       restart;
  } cmd_t;

  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_QUEST  = 8'h3F;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int QUEUE_DEPTH = 2;

  localparam int       CFG_ADDR_W   = 3;
  localparam logic     CFG_IDX_CASE = 1'b0;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic case_sens);
    logic [7:0] r;
    r = c;
    if (!case_sens && c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gwm_if.sv
// ----------------------------------------------------------------------------
// gwm_if
// Request and result channels of the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface gwm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/gwm_front.sv
// ----------------------------------------------------------------------------
// gwm_front
// Accepts requests, parses pattern escapes and emits back-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_front import gwm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  gwm_req_if.sink    req,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  logic loading;
  logic loading_next;
  logic escape;
  logic escape_next;
  logic accept;

  assign req.ready = cmd_ready;
  assign cmd_valid = req.valid;
  assign accept    = req.valid & cmd_ready;

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.kind     = KIND_LIT;
    cmd.chr      = req.char_code;
    cmd.fresh    = 1'b0;
    cmd.restart  = 1'b0;
    loading_next = loading;
    escape_next  = escape;
    unique case (req_type_t'(req.req_type))
      REQ_PAT_CHAR: begin
        cmd.fresh    = !loading;
        loading_next = 1'b1;
        escape_next  = 1'b0;
        if (loading && escape) begin
          cmd.op = OP_STORE;
        end else if (req.char_code == CHR_BSLASH) begin
          escape_next = 1'b1;
        end else if (req.char_code == CHR_STAR) begin
          cmd.op   = OP_STORE;
          cmd.kind = KIND_RUN;
        end else if (req.char_code == CHR_QUEST) begin
          cmd.op   = OP_STORE;
          cmd.kind = KIND_ONE;
        end else begin
          cmd.op = OP_STORE;
        end
      end
      REQ_PAT_END: begin
        cmd.restart  = 1'b1;
        loading_next = 1'b0;
        escape_next  = 1'b0;
      end
      REQ_DATA_CHAR: begin
        cmd.op       = OP_DATA;
        cmd.restart  = loading;
        loading_next = 1'b0;
        escape_next  = 1'b0;
      end
      REQ_DATA_END: begin
        cmd.op       = OP_END;
        cmd.restart  = loading;
        loading_next = 1'b0;
        escape_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loading <= 1'b1;
      escape  <= 1'b0;
    end else if (accept) begin
      loading <= loading_next;
      escape  <= escape_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gwm_fifo.sv
// ----------------------------------------------------------------------------
// gwm_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_fifo import gwm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gwm_back.sv
// ----------------------------------------------------------------------------
// gwm_back
// Element store, active-position set and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_back import gwm_pkg::*; #(
  parameter int PATTERN_ELEMENTS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  cmd_t     cmd,
  input  logic     case_sensitive,
  gwm_res_if.source res
);

  localparam int N     = PATTERN_ELEMENTS;
  localparam int LEN_W = $clog2(N + 1);
  localparam int IDX_W = $clog2(N);
  localparam int LVLS  = $clog2(N + 1);
  localparam logic [N:0] START = (N + 1)'(1);

  kind_t            elem_kind [N];
  logic [7:0]       elem_char [N];
  logic [LEN_W-1:0] length;
  logic             overflow;
  logic [N:0]       active;

  logic [LEN_W-1:0] len_base;
  logic             ovf_base;
  logic             full;
  logic             fire;
  logic [7:0]       data_fold;
  logic [N-1:0]     run;
  logic [N-1:0]     adv;
  logic [N:0]       act_eff;
  logic [N:0]       cur;
  logic [N:0]       nxt;
  logic [N:0]       g_lvl [LVLS+1];
  logic [N:0]       p_lvl [LVLS+1];

  assign cmd_ready = (cmd.op != OP_END) | !res.valid | res.ready;
  assign fire      = cmd_valid & cmd_ready;
  assign len_base  = cmd.fresh ? '0 : length;
  assign ovf_base  = cmd.fresh ? 1'b0 : overflow;
  assign full      = len_base == LEN_W'(N);
  assign data_fold = fold_char(cmd.chr, case_sensitive);
  assign act_eff   = cmd.restart ? START : active;

  for (genvar i = 0; i < N; i++) begin : g_lane
    logic lane_on;
    assign lane_on = LEN_W'(i) < length;
    assign run[i]  = lane_on & (elem_kind[i] == KIND_RUN);
    assign adv[i]  = lane_on & ((elem_kind[i] == KIND_ONE) |
                     ((elem_kind[i] == KIND_LIT) &
                      (fold_char(elem_char[i], case_sensitive) == data_fold)));
  end

  // Star closure as a parallel prefix over the position chain.
  always_comb begin
    g_lvl[0] = act_eff;
    p_lvl[0] = {run, 1'b0};
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j <= N; j++) begin
        if (j >= (1 << l)) begin
          g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
          p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
        end else begin
          g_lvl[l+1][j] = g_lvl[l][j];
          p_lvl[l+1][j] = p_lvl[l][j];
        end
      end
    end
    cur = g_lvl[LVLS];
  end

  always_comb begin
    nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (cur[i] && run[i]) begin
        nxt[i] = 1'b1;
      end
      if (cur[i] && adv[i]) begin
        nxt[i+1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      overflow  <= 1'b0;
      active    <= START;
      res.valid <= 1'b0;
    end else begin
      if (fire) begin
        if (cmd.op == OP_STORE && !full) begin
          length <= len_base + LEN_W'(1);
        end else begin
          length <= len_base;
        end
        if (cmd.op == OP_STORE && full) begin
          overflow <= 1'b1;
        end else begin
          overflow <= ovf_base;
        end
        case (cmd.op)
          OP_DATA: active <= nxt;
          OP_END:  active <= START;
          default: active <= act_eff;
        endcase
      end
      if (fire && cmd.op == OP_END) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd.op == OP_END) begin
      res.matched          <= cur[length] & !overflow;
      res.pattern_overflow <= overflow;
    end
    if (fire && cmd.op == OP_STORE && !full) begin
      elem_kind[len_base[IDX_W-1:0]] <= cmd.kind;
      elem_char[len_base[IDX_W-1:0]] <= cmd.chr;
    end
  end

endmodule

`default_nettype wire

>>> rtl/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Whole-string glob matcher with literal, any-one and any-run elements.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     req_type[1:0], char_code[7:0]
//   res      out  valid/ready     matched, pattern_overflow
//   apb      in   psel/penable    paddr, pwdata, prdata (case_sensitive)
//
// One request per cycle sustained while no stalled result holds the queue;
// the back-end active-position update handles one character per cycle.
// A data-end request passes the command queue; its result is registered
// in the back end. Reset is synchronous; the element store keeps no reset.
// A stalled result stops the queue only at a data-end command; others flow.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher import gwm_pkg::*; #(
  parameter int PATTERN_ELEMENTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  gwm_req_if.sink               req,
  gwm_res_if.source             res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic case_sensitive;
  logic cfg_write;

  cmd_t f_cmd;
  logic f_valid;
  logic f_ready;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == CFG_IDX_CASE) ? {31'b0, case_sensitive} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_sensitive <= 1'b0;
    end else if (cfg_write && paddr[2] == CFG_IDX_CASE) begin
      case_sensitive <= pwdata[0];
    end
  end

  gwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  gwm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  gwm_back #(
    .PATTERN_ELEMENTS (PATTERN_ELEMENTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_valid),
    .cmd_ready      (q_ready),
    .cmd            (q_cmd),
    .case_sensitive (case_sensitive),
    .res            (res)
  );

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.matched && res.pattern_overflow))
    else $error("match reported with pattern overflow");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && paddr[2] == CFG_IDX_CASE) |=> case_sensitive == $past(pwdata[0]))
    else $error("case_sensitive not updated by write");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> q_valid)
    else $error("accepted request missing from queue");

endmodule

`default_nettype wire
